FILE: hw/rtl/rrtd_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher: shared package
// Payload types of both channels, the command and status groups between
// the controller and the datapath, and fixed field widths.
// ----------------------------------------------------------------------------
package rrtd_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned ID_W  = 5;
  localparam int unsigned CPU_W = 3;

  // Action codes of an input item.
  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_SCHED  = 1'b1;

  // One input item.
  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] task_id;
    logic [CPU_W-1:0] cpu;
  } rrtd_in_t;

  // One result item.
  typedef struct packed {
    logic            run_valid;
    logic [ID_W-1:0] run_task;
    logic            switched;
    logic            queue_overflow;
  } rrtd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input item and read the CPU slots
    logic exec;      // create push, or requeue of the deferred task
    logic pop_rd;    // read the ring head and advance it
    logic pop_chk;   // test the popped entry and switch on a hit
    logic finish;    // load the result into the output register
  } rrtd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sched;
    logic cpu_ok;
    logic ring_empty;
    logic pop_hit;
    logic out_free;
  } rrtd_stat_t;

endpackage

FILE: hw/rtl/rrtd_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher: controller
// Sequences one item at a time through execute, ring walk and result
// hand-off, and drives the input stall.
// ----------------------------------------------------------------------------
module rrtd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrtd_pkg::rrtd_stat_t stat_i,
  output rrtd_pkg::rrtd_cmd_t  cmd_o
);
  import rrtd_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_POP_RD  = 3'd2;
  localparam logic [2:0] ST_POP_CHK = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_sched && stat_i.cpu_ok) begin
          state_d = ST_POP_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_POP_RD: begin
        if (stat_i.ring_empty) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        cmd_o.pop_chk = 1'b1;
        if (stat_i.pop_hit) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_POP_RD;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/rrtd_dp.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher: datapath
// Ready ring memory with head and tail pointers, per-task running marks,
// per-CPU current and deferred slots, and the output register.
// ----------------------------------------------------------------------------
module rrtd_dp #(
  parameter int TASK_SLOTS = 32,
  parameter int CPU_COUNT  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrtd_pkg::rrtd_in_t   in_i,
  input  rrtd_pkg::rrtd_cmd_t  cmd_i,
  output rrtd_pkg::rrtd_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rrtd_pkg::rrtd_out_t  out_o
);
  import rrtd_pkg::*;

  localparam int IW  = $clog2(TASK_SLOTS);
  localparam int CIW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  // Storage.
  logic [ID_W-1:0] ring_mem [TASK_SLOTS];
  logic [ID_W-1:0] cur_mem  [CPU_COUNT];
  logic [ID_W-1:0] def_mem  [CPU_COUNT];
  logic [IW-1:0]   head_q, tail_q;
  logic [TASK_SLOTS-1:0] mark_q;
  logic [CPU_COUNT-1:0]  cur_vld_q, def_vld_q;

  // Item and working registers.
  rrtd_in_t        item_q;
  logic [ID_W-1:0] cur_rd_q, def_rd_q, ring_rd_q;
  logic            wk_vld_q, sw_q, ovf_q;
  logic [ID_W-1:0] wk_id_q;
  logic            out_valid_q;
  rrtd_out_t       out_q;

  logic [CIW-1:0]  cidx, in_cidx;
  logic            is_sched, cpu_ok, task_ok;
  logic            push_req, push_ok, ring_full, pop_hit;
  logic [ID_W-1:0] push_id;
  logic [IW-1:0]   tail_nxt, head_nxt;
  logic            mark_we, mark_val;
  logic [IW-1:0]   mark_idx;
  logic            out_free;
  rrtd_out_t       res;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    ring_next = (p == IW'(TASK_SLOTS - 1)) ? '0 : p + IW'(1);
  endfunction

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    id_in_range = (32'(id) < TASK_SLOTS);
  endfunction

  // Item decode.
  assign cidx     = CIW'(item_q.cpu);
  assign in_cidx  = CIW'(in_i.cpu);
  assign is_sched = (item_q.action == ACT_SCHED);
  assign cpu_ok   = (32'(item_q.cpu) < CPU_COUNT);
  assign task_ok  = id_in_range(item_q.task_id);

  // Push of a created task or of the deferred task.
  assign push_req  = is_sched ? (cpu_ok && def_vld_q[cidx]) : task_ok;
  assign push_id   = is_sched ? def_rd_q : item_q.task_id;
  assign tail_nxt  = ring_next(tail_q);
  assign head_nxt  = ring_next(head_q);
  assign ring_full = (tail_nxt == head_q);
  assign push_ok   = cmd_i.exec && push_req && !ring_full;

  // A popped entry is taken when it names a task that is not running.
  assign pop_hit = id_in_range(ring_rd_q) && !mark_q[IW'(ring_rd_q)];

  // Running mark write port: cleared on push, set on a switch.
  always_comb begin
    mark_we  = 1'b0;
    mark_val = 1'b0;
    mark_idx = IW'(push_id);
    if (cmd_i.exec && push_req && id_in_range(push_id)) begin
      mark_we = 1'b1;
    end else if (cmd_i.pop_chk && pop_hit) begin
      mark_we  = 1'b1;
      mark_val = 1'b1;
      mark_idx = IW'(ring_rd_q);
    end
  end

  // Result of the finished item.
  always_comb begin
    res                = '0;
    res.run_valid      = is_sched && cpu_ok && wk_vld_q;
    res.run_task       = res.run_valid ? wk_id_q : '0;
    res.switched       = sw_q;
    res.queue_overflow = ovf_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Memories and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q   <= in_i;
      cur_rd_q <= cur_mem[in_cidx];
      def_rd_q <= def_mem[in_cidx];
    end
    if (push_ok) begin
      ring_mem[tail_q] <= push_id;
    end
    if (cmd_i.exec) begin
      wk_id_q <= cur_rd_q;
    end
    if (cmd_i.pop_rd) begin
      ring_rd_q <= ring_mem[head_q];
    end
    if (cmd_i.pop_chk && pop_hit) begin
      cur_mem[cidx] <= ring_rd_q;
      def_mem[cidx] <= wk_id_q;
      wk_id_q       <= ring_rd_q;
    end
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      mark_q      <= '0;
      cur_vld_q   <= '0;
      def_vld_q   <= '0;
      wk_vld_q    <= 1'b0;
      sw_q        <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        sw_q  <= 1'b0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        wk_vld_q <= is_sched && cpu_ok && cur_vld_q[cidx];
        if (push_req && ring_full) begin
          ovf_q <= 1'b1;
        end
        if (is_sched && cpu_ok) begin
          def_vld_q[cidx] <= 1'b0;
        end
      end
      if (push_ok) begin
        tail_q <= tail_nxt;
      end
      if (mark_we) begin
        mark_q[mark_idx] <= mark_val;
      end
      if (cmd_i.pop_rd) begin
        head_q <= head_nxt;
      end
      if (cmd_i.pop_chk && pop_hit) begin
        cur_vld_q[cidx] <= 1'b1;
        def_vld_q[cidx] <= wk_vld_q;
        wk_vld_q        <= 1'b1;
        sw_q            <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.is_sched   = is_sched;
    stat_o.cpu_ok     = cpu_ok;
    stat_o.ring_empty = (head_q == tail_q);
    stat_o.pop_hit    = pop_hit;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hw/rtl/round_robin_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher core
// Ring queue of ready task ids shared by several CPUs; create items enqueue
// a task, schedule items requeue the CPU's deferred task and pick the next
// runnable one.
//
//   Channel  Direction  Handshake                     Payload
//   in       input      in_valid_i / in_stall_o       rrtd_in_t  in_i
//   out      output     out_valid_o / out_stall_i     rrtd_out_t out_o
//
// A create item passes through the execute and finish states. A schedule item
// for a valid CPU also walks the ring: a read and a check state per popped
// entry and a last read if none is runnable; pops use the single ring port.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
// Reset clears the pointers, running marks and CPU slot valid bits at once.
// ----------------------------------------------------------------------------
module round_robin_task_dispatcher_core #(
  parameter int TASK_SLOTS = 32,
  parameter int CPU_COUNT  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrtd_pkg::rrtd_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrtd_pkg::rrtd_out_t out_o
);
  import rrtd_pkg::*;

  rrtd_cmd_t  cmd;
  rrtd_stat_t stat;

  // Sequencer.
  rrtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Queue, marks and CPU slots.
  rrtd_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .CPU_COUNT  (CPU_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // A transfer in starts the work, so the input stalls in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A switch always leaves the CPU with a task to run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.switched) |-> out_o.run_valid)
    else $error("switch reported without a running task");

  // Without a task to run the task id reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.run_valid) |-> (out_o.run_task == '0))
    else $error("task id set without a running task");

  // The ring is only walked for a schedule on a valid CPU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_rd |-> (stat.is_sched && stat.cpu_ok))
    else $error("ring pop outside a schedule");

endmodule
